/* hdl/lav_pkg.sv */
// shared widths and constants for the look-at view matrix pipeline
`timescale 1ns / 1ps
package lav_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int MAG_W = 30;          // magnitude after block scaling, lead bit at 29
  localparam int SCL_W = MAG_W + 1;   // signed block-scaled component
  localparam int LEN_W = 31;          // vector length, also quotient width
  localparam int UNIT_W = 32;         // signed Q2.30 unit component
  localparam int ENT_W = 32;          // one matrix entry
  localparam int N_ENT = 12;
  localparam int RND_SH = 30;
endpackage

/* hdl/lav_prescale.sv */
// block scaling of a signed 3-vector so that its largest magnitude has its lead bit at 29
`timescale 1ns / 1ps
module lav_prescale #(
  parameter int VW = 33,
  parameter int SIDE_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [VW-1:0] vec [3],
  input  logic [SIDE_W-1:0] side,
  output logic out_valid,
  output logic signed [lav_pkg::SCL_W-1:0] sc [3],
  output logic nz,
  output logic [SIDE_W-1:0] side_out
);
  import lav_pkg::*;
  localparam int PW = $clog2(VW);
  localparam int TW = VW + MAG_W;

  logic v1, v2;
  logic [VW-1:0] mag1 [3];
  logic [VW-1:0] mag2 [3];
  logic [2:0] neg1, neg2;
  logic [VW-1:0] orm1;
  logic [PW-1:0] lead, lead2;
  logic nz2;
  logic [SIDE_W-1:0] side1, side2;
  logic [TW-1:0] wide [3];
  logic signed [SCL_W-1:0] scv [3];

  // the lead bit of the largest magnitude is the lead bit of their or
  always_comb begin
    lead = '0;
    for (int b = 0; b < VW; b++) begin
      if (orm1[b]) lead = PW'(b);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (int'(lead2) >= MAG_W - 1) begin
        wide[i] = TW'(mag2[i]) >> (int'(lead2) - (MAG_W - 1));
      end else begin
        wide[i] = TW'(mag2[i]) << ((MAG_W - 1) - int'(lead2));
      end
      scv[i] = $signed({1'b0, wide[i][MAG_W-1:0]});
      if (neg2[i]) scv[i] = -scv[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= vec[i][VW-1];
        mag1[i] <= vec[i][VW-1] ? VW'(-vec[i]) : VW'(vec[i]);
        mag2[i] <= mag1[i];
        sc[i] <= scv[i];
      end
      orm1 <= (vec[0][VW-1] ? VW'(-vec[0]) : VW'(vec[0]))
            | (vec[1][VW-1] ? VW'(-vec[1]) : VW'(vec[1]))
            | (vec[2][VW-1] ? VW'(-vec[2]) : VW'(vec[2]));
      neg2 <= neg1;
      lead2 <= lead;
      nz2 <= |orm1;
      nz <= nz2;
      side1 <= side;
      side2 <= side1;
      side_out <= side2;
    end
  end
endmodule

/* hdl/lav_norm.sv */
// pipelined normalisation: block scaling, sum of squares, bit-serial root, long division
`timescale 1ns / 1ps
module lav_norm #(
  parameter int VW = 33,
  parameter int SIDE_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [VW-1:0] vec [3],
  input  logic [SIDE_W-1:0] side,
  output logic out_valid,
  output logic signed [lav_pkg::UNIT_W-1:0] unit [3],
  output logic [SIDE_W-1:0] side_out
);
  import lav_pkg::*;
  localparam int STEPS = LEN_W;
  localparam int RW = LEN_W + 2;
  localparam int SQ_W = 2 * MAG_W;
  localparam int SUM_W = 2 * LEN_W;
  localparam int NEG_LSB = 3 * MAG_W;
  localparam int NZ_BIT = NEG_LSB + 3;
  localparam int SIDE_LSB = NZ_BIT + 1;
  localparam int CRW = SIDE_LSB + SIDE_W;

  logic ps_valid, ps_nz;
  logic signed [SCL_W-1:0] ps_a [3];
  logic [SIDE_W-1:0] ps_side;
  logic [MAG_W-1:0] ps_mag [3];
  logic [2:0] ps_neg;

  lav_prescale #(.VW(VW), .SIDE_W(SIDE_W)) u_scale (
    .clk, .rst, .en, .in_valid, .vec, .side,
    .out_valid(ps_valid), .sc(ps_a), .nz(ps_nz), .side_out(ps_side)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ps_neg[i] = ps_a[i][SCL_W-1];
      ps_mag[i] = ps_neg[i] ? MAG_W'(-ps_a[i]) : MAG_W'(ps_a[i]);
    end
  end

  logic v1, v2;
  logic [CRW-1:0] cr1, cr2;
  logic [SQ_W-1:0] sq1 [3];
  logic [SUM_W-1:0] sum2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= ps_valid;
      v2 <= v1;
    end
    if (en) begin
      cr1 <= {ps_side, ps_nz, ps_neg, ps_mag[2], ps_mag[1], ps_mag[0]};
      for (int i = 0; i < 3; i++) sq1[i] <= SQ_W'(ps_mag[i]) * SQ_W'(ps_mag[i]);
      cr2 <= cr1;
      sum2 <= SUM_W'(sq1[0]) + SUM_W'(sq1[1]) + SUM_W'(sq1[2]);
    end
  end

  // square root, one result bit per stage
  logic sq_v [STEPS];
  logic [CRW-1:0] sq_cr [STEPS];
  logic [RW-1:0] sq_rem [STEPS];
  logic [LEN_W-1:0] sq_root [STEPS];
  logic [SUM_W-1:0] sq_n [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_sqrt
    logic pv;
    logic [CRW-1:0] pcr;
    logic [RW-1:0] prem, rem_t, trial;
    logic [LEN_W-1:0] proot;
    logic [SUM_W-1:0] pn;
    if (k == 0) begin : g_first
      assign pv = v2;
      assign pcr = cr2;
      assign prem = '0;
      assign proot = '0;
      assign pn = sum2;
    end else begin : g_next
      assign pv = sq_v[k-1];
      assign pcr = sq_cr[k-1];
      assign prem = sq_rem[k-1];
      assign proot = sq_root[k-1];
      assign pn = sq_n[k-1];
    end
    always_comb begin
      rem_t = {prem[RW-3:0], pn[SUM_W-1 -: 2]};
      trial = {proot, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sq_v[k] <= 1'b0;
      else if (en) sq_v[k] <= pv;
      if (en) begin
        sq_cr[k] <= pcr;
        sq_n[k] <= pn << 2;
        if (rem_t >= trial) begin
          sq_rem[k] <= rem_t - trial;
          sq_root[k] <= {proot[LEN_W-2:0], 1'b1};
        end else begin
          sq_rem[k] <= rem_t;
          sq_root[k] <= {proot[LEN_W-2:0], 1'b0};
        end
      end
    end
  end

  // restoring division of magnitude * 2^30 by the length, three lanes
  logic dv_v [STEPS];
  logic [CRW-1:0] dv_cr [STEPS];
  logic [LEN_W-1:0] dv_len [STEPS];
  logic [LEN_W-1:0] dv_rem [STEPS][3];
  logic [LEN_W-1:0] dv_q [STEPS][3];

  for (genvar k = 0; k < STEPS; k++) begin : g_div
    logic pv;
    logic [CRW-1:0] pcr;
    logic [LEN_W-1:0] plen;
    logic [LEN_W:0] rt [3];
    logic [LEN_W-1:0] pq [3];
    if (k == 0) begin : g_first
      assign pv = sq_v[STEPS-1];
      assign pcr = sq_cr[STEPS-1];
      assign plen = sq_root[STEPS-1];
      // the first step sees the whole magnitude, which never exceeds the length
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rt[i] = (LEN_W + 1)'(pcr[i*MAG_W +: MAG_W]);
          pq[i] = '0;
        end
      end
    end else begin : g_next
      assign pv = dv_v[k-1];
      assign pcr = dv_cr[k-1];
      assign plen = dv_len[k-1];
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rt[i] = {dv_rem[k-1][i], 1'b0};
          pq[i] = dv_q[k-1][i];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv_v[k] <= 1'b0;
      else if (en) dv_v[k] <= pv;
      if (en) begin
        dv_cr[k] <= pcr;
        dv_len[k] <= plen;
        for (int i = 0; i < 3; i++) begin
          if (rt[i] >= {1'b0, plen}) begin
            dv_rem[k][i] <= LEN_W'(rt[i] - {1'b0, plen});
            dv_q[k][i] <= {pq[i][LEN_W-2:0], 1'b1};
          end else begin
            dv_rem[k][i] <= LEN_W'(rt[i]);
            dv_q[k][i] <= {pq[i][LEN_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic [CRW-1:0] lcr;
  assign lcr = dv_cr[STEPS-1];
  assign out_valid = dv_v[STEPS-1];
  assign side_out = lcr[SIDE_LSB +: SIDE_W];

  // zero vector gives the zero vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!lcr[NZ_BIT]) unit[i] = '0;
      else if (lcr[NEG_LSB+i]) unit[i] = -$signed(UNIT_W'(dv_q[STEPS-1][i]));
      else unit[i] = $signed(UNIT_W'(dv_q[STEPS-1][i]));
    end
  end
endmodule

/* hdl/lav_outq.sv */
// two-entry output queue that decouples the pipeline from the result receiver
`timescale 1ns / 1ps
module lav_outq #(
  parameter int W = 384
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  logic [W-1:0] push_data,
  output logic ready,
  output logic tvalid,
  input  logic tready,
  output logic [W-1:0] tdata
);
  logic [1:0] cnt, cnt_next;
  logic [W-1:0] head, spare;
  logic push, pop;

  assign ready = (cnt != 2'd2);
  assign push = push_valid && ready;
  assign tvalid = (cnt != 2'd0);
  assign pop = tvalid && tready;
  assign tdata = head;
  assign cnt_next = cnt + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) cnt <= 2'd0;
    else cnt <= cnt_next;
    case (cnt)
      2'd0: begin
        if (push) head <= push_data;
      end
      2'd1: begin
        if (push && pop) head <= push_data;
        else if (push) spare <= push_data;
      end
      default: begin
        if (pop) head <= spare;
      end
    endcase
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("output queue count out of range");
  a_push_shows: assert property (@(posedge clk) disable iff (rst) (push && !pop) |=> tvalid)
    else $error("pushed result not offered");
  a_spare_moves: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && pop) |=> (head == $past(spare) && cnt == 2'd1))
    else $error("queued result lost on drain");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !tready) |=> (cnt == 2'd2 && $stable(head) && !ready))
    else $error("full queue changed while stalled");
`endif
endmodule

/* hdl/look_at_view_matrix.sv */
// look-at view matrix set-up pipeline, top level
//
// input channel s_axis carries one view set-up per transfer: eye, target and up
// points, each axis signed fixed point of COORD_WIDTH bits. output channel m_axis
// carries the twelve matrix entries: the rotation rows side, true up and negated
// forward as Q2.30, and the translation as saturated input-format values.
// the pipeline takes one transfer per cycle unless stalled; its depth is set
// by the two normalisations, each a 31-stage square root followed by a
// 31-stage divider, plus block scaling, cross products and the dot products
// for translation.
// all stages advance together under one enable taken from a two-entry output
// queue, so a result may wait on m_axis while the next input is still taken;
// only when both queue entries are held does s_axis_tready fall and the whole
// pipeline freeze, losing nothing.
// synchronous reset clears all valid bits and empties the queue; no results
// are in flight afterwards.
`timescale 1ns / 1ps
module look_at_view_matrix #(
  parameter int COORD_WIDTH = lav_pkg::COORD_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // side_x, upv_x, back_x, side_y, upv_y, back_y, side_z, upv_z, back_z,
  // shift_x, shift_y, shift_z
  output logic [lav_pkg::N_ENT*lav_pkg::ENT_W-1:0] m_axis_tdata
);
  import lav_pkg::*;
  localparam int CW = COORD_WIDTH;
  localparam int DW = CW + 1;
  localparam int SPL = CW / 2;
  localparam int HI_W = CW - SPL;
  localparam int LO_W = SPL + 1;
  localparam int PH_W = UNIT_W + HI_W;
  localparam int PL_W = UNIT_W + LO_W;
  localparam int HS_W = PH_W + 2;
  localparam int LS_W = PL_W + 2;
  localparam int TOT_W = UNIT_W + CW + 4;
  localparam int CX_W = UNIT_W + SCL_W;
  localparam int PU_W = 2 * UNIT_W;
  localparam int SAT_W = PU_W + TOT_W;
  localparam int SU_W = 3 * CW + 3 * DW;
  localparam int S1_W = 3 * CW + 3 * SCL_W;
  localparam int S2_W = 3 * CW + 3 * UNIT_W;
  localparam int OUT_W = N_ENT * ENT_W;
  localparam logic signed [PU_W-1:0] HALF_U = PU_W'(64'd1 << (RND_SH - 1));
  localparam logic signed [TOT_W-1:0] HALF_T = TOT_W'(64'd1 << (RND_SH - 1));

  function automatic logic signed [ENT_W-1:0] sat_ent(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] lim_hi, lim_lo;
    lim_hi = SAT_W'({1'b0, {(ENT_W-1){1'b1}}});
    lim_lo = -lim_hi - 1;
    if (x > lim_hi) return {1'b0, {(ENT_W-1){1'b1}}};
    else if (x < lim_lo) return {1'b1, {(ENT_W-1){1'b0}}};
    else return ENT_W'(x);
  endfunction

  logic en;
  logic push_valid;
  logic [OUT_W-1:0] push_data;

  assign s_axis_tready = en;

  // input register, forward difference
  logic signed [CW-1:0] eye [3];
  logic signed [CW-1:0] tgt [3];
  logic signed [CW-1:0] upin [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye[i] = s_axis_tdata[i*CW +: CW];
      tgt[i] = s_axis_tdata[(3+i)*CW +: CW];
      upin[i] = s_axis_tdata[(6+i)*CW +: CW];
    end
  end

  logic v0;
  logic signed [CW-1:0] e0 [3];
  logic signed [CW-1:0] up0 [3];
  logic signed [DW-1:0] d0 [3];
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e0[i] <= eye[i];
        up0[i] <= upin[i];
        d0[i] <= DW'(tgt[i]) - DW'(eye[i]);
      end
    end
  end

  // up direction is only block-scaled
  logic vu;
  logic [SU_W-1:0] su_in, su_out;
  logic signed [SCL_W-1:0] ua [3];
  assign su_in = {e0[2], e0[1], e0[0], d0[2], d0[1], d0[0]};

  lav_prescale #(.VW(CW), .SIDE_W(SU_W)) u_up_scale (
    .clk, .rst, .en, .in_valid(v0), .vec(up0), .side(su_in),
    .out_valid(vu), .sc(ua), .nz(), .side_out(su_out)
  );

  logic signed [DW-1:0] d_u [3];
  logic [S1_W-1:0] s1_in, s1_out;
  always_comb begin
    for (int i = 0; i < 3; i++) d_u[i] = su_out[i*DW +: DW];
  end
  assign s1_in = {su_out[3*DW +: 3*CW], ua[2], ua[1], ua[0]};

  logic vf;
  logic signed [UNIT_W-1:0] f1 [3];
  lav_norm #(.VW(DW), .SIDE_W(S1_W)) u_fwd_norm (
    .clk, .rst, .en, .in_valid(vu), .vec(d_u), .side(s1_in),
    .out_valid(vf), .unit(f1), .side_out(s1_out)
  );

  // forward cross up
  logic signed [SCL_W-1:0] ua_n [3];
  always_comb begin
    for (int i = 0; i < 3; i++) ua_n[i] = s1_out[i*SCL_W +: SCL_W];
  end

  logic vx1, vx2;
  logic [3*CW-1:0] e_x1, e_x2;
  logic signed [UNIT_W-1:0] f_x1 [3];
  logic signed [UNIT_W-1:0] f_x2 [3];
  logic signed [CX_W-1:0] px [6];
  logic signed [CX_W-1:0] cx [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      vx1 <= 1'b0;
      vx2 <= 1'b0;
    end else if (en) begin
      vx1 <= vf;
      vx2 <= vx1;
    end
    if (en) begin
      e_x1 <= s1_out[3*SCL_W +: 3*CW];
      f_x1 <= f1;
      px[0] <= f1[1] * ua_n[2];
      px[1] <= f1[2] * ua_n[1];
      px[2] <= f1[2] * ua_n[0];
      px[3] <= f1[0] * ua_n[2];
      px[4] <= f1[0] * ua_n[1];
      px[5] <= f1[1] * ua_n[0];
      e_x2 <= e_x1;
      f_x2 <= f_x1;
      for (int i = 0; i < 3; i++) cx[i] <= px[2*i] - px[2*i+1];
    end
  end

  logic [S2_W-1:0] s2_in, s2_out;
  assign s2_in = {e_x2, f_x2[2], f_x2[1], f_x2[0]};

  logic vs;
  logic signed [UNIT_W-1:0] s2 [3];
  lav_norm #(.VW(CX_W), .SIDE_W(S2_W)) u_side_norm (
    .clk, .rst, .en, .in_valid(vx2), .vec(cx), .side(s2_in),
    .out_valid(vs), .unit(s2), .side_out(s2_out)
  );

  // true up = side cross forward, rounded to Q2.30
  logic signed [UNIT_W-1:0] f_n2 [3];
  always_comb begin
    for (int i = 0; i < 3; i++) f_n2[i] = s2_out[i*UNIT_W +: UNIT_W];
  end

  logic vu1, vu2;
  logic [3*CW-1:0] e_u1, e_u2;
  logic signed [UNIT_W-1:0] s_u1 [3];
  logic signed [UNIT_W-1:0] f_u1 [3];
  logic signed [UNIT_W-1:0] s_u2 [3];
  logic signed [UNIT_W-1:0] f_u2 [3];
  logic signed [UNIT_W-1:0] u_u2 [3];
  logic signed [PU_W-1:0] pu [6];
  logic signed [PU_W-1:0] ud [3];
  always_comb begin
    for (int i = 0; i < 3; i++) ud[i] = (pu[2*i] - pu[2*i+1] + HALF_U) >>> RND_SH;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vu1 <= 1'b0;
      vu2 <= 1'b0;
    end else if (en) begin
      vu1 <= vs;
      vu2 <= vu1;
    end
    if (en) begin
      e_u1 <= s2_out[3*UNIT_W +: 3*CW];
      s_u1 <= s2;
      f_u1 <= f_n2;
      pu[0] <= s2[1] * f_n2[2];
      pu[1] <= s2[2] * f_n2[1];
      pu[2] <= s2[2] * f_n2[0];
      pu[3] <= s2[0] * f_n2[2];
      pu[4] <= s2[0] * f_n2[1];
      pu[5] <= s2[1] * f_n2[0];
      e_u2 <= e_u1;
      s_u2 <= s_u1;
      f_u2 <= f_u1;
      for (int i = 0; i < 3; i++) u_u2[i] <= sat_ent(SAT_W'(ud[i]));
    end
  end

  // translation: eye split into high and low halves for the products
  logic signed [UNIT_W-1:0] qv [3][3];
  logic signed [HI_W-1:0] e_hi [3];
  logic signed [LO_W-1:0] e_lo [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qv[0][i] = s_u2[i];
      qv[1][i] = u_u2[i];
      qv[2][i] = f_u2[i];
      e_hi[i] = HI_W'($signed(e_u2[i*CW +: CW]) >>> SPL);
      e_lo[i] = $signed({1'b0, e_u2[i*CW +: SPL]});
    end
  end

  logic vd1, vd2, vd3;
  logic signed [UNIT_W-1:0] qd1 [3][3];
  logic signed [UNIT_W-1:0] qd2 [3][3];
  logic signed [UNIT_W-1:0] qd3 [3][3];
  logic signed [PH_W-1:0] ph [3][3];
  logic signed [PL_W-1:0] pl [3][3];
  logic signed [HS_W-1:0] hs [3];
  logic signed [LS_W-1:0] ls [3];
  logic signed [TOT_W-1:0] tot [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      vd1 <= 1'b0;
      vd2 <= 1'b0;
      vd3 <= 1'b0;
    end else if (en) begin
      vd1 <= vu2;
      vd2 <= vd1;
      vd3 <= vd2;
    end
    if (en) begin
      qd1 <= qv;
      qd2 <= qd1;
      qd3 <= qd2;
      for (int g = 0; g < 3; g++) begin
        for (int i = 0; i < 3; i++) begin
          ph[g][i] <= qv[g][i] * e_hi[i];
          pl[g][i] <= qv[g][i] * e_lo[i];
        end
        hs[g] <= HS_W'(ph[g][0]) + HS_W'(ph[g][1]) + HS_W'(ph[g][2]);
        ls[g] <= LS_W'(pl[g][0]) + LS_W'(pl[g][1]) + LS_W'(pl[g][2]);
        tot[g] <= (TOT_W'(hs[g]) <<< SPL) + TOT_W'(ls[g]) + HALF_T;
      end
    end
  end

  logic signed [TOT_W-1:0] rr [3];
  logic signed [ENT_W-1:0] ent [N_ENT];
  always_comb begin
    for (int g = 0; g < 3; g++) rr[g] = tot[g] >>> RND_SH;
    for (int i = 0; i < 3; i++) begin
      ent[3*i] = qd3[0][i];
      ent[3*i+1] = qd3[1][i];
      ent[3*i+2] = -qd3[2][i];
    end
    ent[9] = sat_ent(SAT_W'(-rr[0]));
    ent[10] = sat_ent(SAT_W'(-rr[1]));
    ent[11] = sat_ent(SAT_W'(rr[2]));
    for (int k = 0; k < N_ENT; k++) push_data[k*ENT_W +: ENT_W] = ent[k];
  end
  assign push_valid = vd3;

  lav_outq #(.W(OUT_W)) u_outq (
    .clk, .rst, .push_valid, .push_data, .ready(en),
    .tvalid(m_axis_tvalid), .tready(m_axis_tready), .tdata(m_axis_tdata)
  );
endmodule
